// File: hw/rtl/fixed_point_q8_alu_defines.svh
// ----------------------------------------------------------------------------
// Fixed-point ALU assertion macros
// Shared concurrent assertion forms for the RTL.
// ----------------------------------------------------------------------------
`ifndef FIXED_POINT_Q8_ALU_DEFINES_SVH
`define FIXED_POINT_Q8_ALU_DEFINES_SVH

// consequent holds in the same cycle as the trigger
`define FQA_ASSERT_SAME(label, clk, rst, trig, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) \
      else $error("assertion failed");

// consequent holds in the cycle after the trigger
`define FQA_ASSERT_NEXT(label, clk, rst, trig, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: hw/rtl/fqa_pkg.sv
// ----------------------------------------------------------------------------
// Fixed-point ALU package
// Operation codes and transaction payload types.
// ----------------------------------------------------------------------------
package fqa_pkg;

   localparam int unsigned IO_WIDTH = 32;

   typedef enum logic [3:0] {
      OP_ADD  = 4'd0,
      OP_SUB  = 4'd1,
      OP_MUL  = 4'd2,
      OP_DIV  = 4'd3,
      OP_CMP  = 4'd4,
      OP_MIN  = 4'd5,
      OP_MAX  = 4'd6,
      OP_INC  = 4'd7,
      OP_DEC  = 4'd8,
      OP_I2F  = 4'd9,
      OP_F2I  = 4'd10
   } op_type;

   typedef struct packed {
      logic [3:0]                  req_type;
      logic signed [IO_WIDTH-1:0]  operand_a;
      logic signed [IO_WIDTH-1:0]  operand_b;
   } req_type_t_type;

   typedef struct packed {
      logic signed [IO_WIDTH-1:0]  result_raw;
      logic                        a_greater;
      logic                        a_less;
      logic                        a_equal;
      logic                        overflow_flag;
      logic                        divide_by_zero;
   } rsp_type;

   // per-stage control carried along the chain
   typedef struct packed {
      logic       valid;
      logic [3:0] op;
      logic       neg;
      logic       dz;
   } ctl_type;

endpackage

// File: hw/rtl/fqa_div_cell.sv
// ----------------------------------------------------------------------------
// Fixed-point ALU divider cell
// One restoring division step; passes remainder and quotient to its neighbor.
// ----------------------------------------------------------------------------
module fqa_div_cell
   import fqa_pkg::*;
#(
   parameter int unsigned NW = 48,
   parameter int unsigned DW = 32,
   parameter int unsigned PW = 64,
   parameter int unsigned BIT = 0
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            en,
   input  ctl_type         ctl_in,
   input  logic [NW-1:0]   num_in,
   input  logic [DW-1:0]   den_in,
   input  logic [DW-1:0]   rem_in,
   input  logic [NW-1:0]   quo_in,
   input  logic [PW-1:0]   pay_in,
   output ctl_type         ctl_out,
   output logic [NW-1:0]   num_out,
   output logic [DW-1:0]   den_out,
   output logic [DW-1:0]   rem_out,
   output logic [NW-1:0]   quo_out,
   output logic [PW-1:0]   pay_out
);

   logic [DW+1:0] trial;
   logic [DW:0]   shifted;
   logic [DW-1:0] rem_in_nx;
   logic [NW-1:0] quo_in_nx;

   // remainder stays below the divisor, so it fits in DW bits
   always_comb begin
      shifted   = {rem_in, num_in[BIT]};
      trial     = {1'b0, shifted} - {2'b00, den_in};
      rem_in_nx = shifted[DW-1:0];
      quo_in_nx = quo_in;
      if (!trial[DW+1]) begin
         rem_in_nx = trial[DW-1:0];
         quo_in_nx[BIT] = 1'b1;
      end
   end

   ctl_type       ctl_ff;
   logic [NW-1:0] num_ff;
   logic [DW-1:0] den_ff;
   logic [DW-1:0] rem_ff;
   logic [NW-1:0] quo_ff;
   logic [PW-1:0] pay_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (en) begin
         ctl_ff.valid <= ctl_in.valid;
      end
      if (en) begin
         ctl_ff.op  <= ctl_in.op;
         ctl_ff.neg <= ctl_in.neg;
         ctl_ff.dz  <= ctl_in.dz;
         num_ff <= num_in;
         den_ff <= den_in;
         rem_ff <= rem_in_nx;
         quo_ff <= quo_in_nx;
         pay_ff <= pay_in;
      end
   end

   assign ctl_out = ctl_ff;
   assign num_out = num_ff;
   assign den_out = den_ff;
   assign rem_out = rem_ff;
   assign quo_out = quo_ff;
   assign pay_out = pay_ff;

endmodule

// File: hw/rtl/fixed_point_q8_alu.sv
// ----------------------------------------------------------------------------
// Fixed-point ALU, Q(WORD_WIDTH-FRAC_BITS).FRAC_BITS, saturating
// Pipelined: one transaction per cycle while the result side does not stall, fixed latency for every operation.
// ----------------------------------------------------------------------------
// Accepts one transaction every cycle while rsp_stall is low. Each result passes
// through the operand-capture register, the stage-1 register, the chain of
// divider cells, one quotient bit per cell, and the output register; all other
// operations ride alongside in the same chain. A stall on the result side while
// a result is valid freezes the whole chain.
module fixed_point_q8_alu
   import fqa_pkg::*;
#(
   parameter int unsigned FRAC_BITS  = 8,
   parameter int unsigned WORD_WIDTH = 32
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_type_t_type  req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_type         rsp_data
);

`include "fixed_point_q8_alu_defines.svh"

   localparam int unsigned W  = WORD_WIDTH;
   localparam int unsigned NW = W + FRAC_BITS + 1;
   localparam int unsigned PW = 2 * W;
   localparam int unsigned PWX = 2 * W + 2;

   // divide by zero: sign of a alone; neg flag xor sign of zero b equals sign of a
   function automatic logic [W-1:0] s_sign_sat(input logic neg_a, input logic unused_b);
      logic [W-1:0] r;
      r = (neg_a & unused_b) ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      return r;
   endfunction

   logic adv;
   assign adv = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;

   // ---- stage 0: operand capture
   ctl_type             s0_ctl_ff;
   logic signed [W-1:0] s0_a_ff, s0_b_ff;

   logic signed [W-1:0] a_ext, b_ext;
   assign a_ext = W'(req_data.operand_a);
   assign b_ext = W'(req_data.operand_b);

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_ctl_ff.valid <= 1'b0;
      end else if (adv) begin
         s0_ctl_ff.valid <= req_valid;
      end
      if (adv) begin
         s0_ctl_ff.op  <= req_data.req_type;
         s0_ctl_ff.neg <= a_ext[W-1] ^ b_ext[W-1];
         s0_ctl_ff.dz  <= (b_ext == '0);
         s0_a_ff       <= a_ext;
         s0_b_ff       <= b_ext;
      end
   end

   // ---- stage 1: simple ops, magnitudes, multiplier
   logic [W-1:0] mag_a, mag_b;
   assign mag_a = s0_a_ff[W-1] ? W'(-s0_a_ff) : s0_a_ff;
   assign mag_b = s0_b_ff[W-1] ? W'(-s0_b_ff) : s0_b_ff;

   logic signed [W-1:0] mx, mn;
   assign mx = {1'b0, {(W-1){1'b1}}};
   assign mn = {1'b1, {(W-1){1'b0}}};

   // simple-result payload: result, gt, lt, eq, ovf
   logic [W-1:0] sres;
   logic sgt, slt_f, seq, sovf;
   logic signed [W-1:0] sum;
   logic signed [W-1:0] i2f_hi, i2f_lo;
   assign i2f_hi = mx >>> FRAC_BITS;
   assign i2f_lo = mn >>> FRAC_BITS;

   always_comb begin
      sres = '0; sgt = 1'b0; slt_f = 1'b0; seq = 1'b0; sovf = 1'b0; sum = '0;
      case (s0_ctl_ff.op)
         OP_ADD: begin
            sum = s0_a_ff + s0_b_ff;
            sres = sum;
            if (s0_a_ff[W-1] == s0_b_ff[W-1] && sum[W-1] != s0_a_ff[W-1]) begin
               sovf = 1'b1;
               sres = s0_a_ff[W-1] ? mn : mx;
            end
         end
         OP_SUB: begin
            sum = s0_a_ff - s0_b_ff;
            sres = sum;
            if (s0_a_ff[W-1] != s0_b_ff[W-1] && sum[W-1] != s0_a_ff[W-1]) begin
               sovf = 1'b1;
               sres = s0_a_ff[W-1] ? mn : mx;
            end
         end
         OP_CMP, OP_MIN, OP_MAX: begin
            sgt = s0_a_ff > s0_b_ff;
            slt_f = s0_a_ff < s0_b_ff;
            seq = s0_a_ff == s0_b_ff;
            if (s0_ctl_ff.op == OP_MIN) sres = slt_f ? s0_a_ff : s0_b_ff;
            else if (s0_ctl_ff.op == OP_MAX) sres = sgt ? s0_a_ff : s0_b_ff;
         end
         OP_INC: begin
            if (s0_a_ff == mx) begin sovf = 1'b1; sres = mx; end
            else sres = s0_a_ff + W'(1);
         end
         OP_DEC: begin
            if (s0_a_ff == mn) begin sovf = 1'b1; sres = mn; end
            else sres = s0_a_ff - W'(1);
         end
         OP_I2F: begin
            if (s0_a_ff > i2f_hi) begin sovf = 1'b1; sres = mx; end
            else if (s0_a_ff < i2f_lo) begin sovf = 1'b1; sres = mn; end
            else sres = s0_a_ff <<< FRAC_BITS;
         end
         OP_F2I: sres = s0_a_ff >>> FRAC_BITS;
         default: ;
      endcase
   end

   // multiplier split in two halves of the b operand to bound width
   localparam int unsigned HB = W / 2;
   logic [W+HB-1:0] pp_lo, pp_hi;
   assign pp_lo = {{HB{1'b0}}, mag_a} * {{W{1'b0}}, mag_b[HB-1:0]};
   assign pp_hi = {{HB{1'b0}}, mag_a} * {{W{1'b0}}, mag_b[W-1:HB]};

   ctl_type             s1_ctl_ff;
   logic [W+HB-1:0]     s1_pl_ff, s1_ph_ff;
   logic [W-1:0]        s1_ma_ff, s1_mb_ff;
   logic [W+3:0]        s1_simple_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff.valid <= 1'b0;
      end else if (adv) begin
         s1_ctl_ff.valid <= s0_ctl_ff.valid;
      end
      if (adv) begin
         s1_ctl_ff.op  <= s0_ctl_ff.op;
         s1_ctl_ff.neg <= s0_ctl_ff.neg;
         s1_ctl_ff.dz  <= s0_ctl_ff.dz;
         s1_pl_ff      <= pp_lo;
         s1_ph_ff      <= pp_hi;
         s1_ma_ff      <= mag_a;
         s1_mb_ff      <= mag_b;
         s1_simple_ff  <= {sres, sgt, slt_f, seq, sovf};
      end
   end

   // ---- stage 2: product sum, divider entry
   logic [PW-1:0] prod;
   assign prod = PW'(s1_pl_ff) + (PW'(s1_ph_ff) << HB);

   localparam int unsigned CW = PW + W + 4;
   logic [NW-1:0] num0;
   assign num0 = NW'({s1_ma_ff, {(FRAC_BITS+1){1'b0}}});

   ctl_type       c_ctl [0:NW];
   logic [NW-1:0] c_num [0:NW];
   logic [W-1:0]  c_den [0:NW];
   logic [W-1:0]  c_rem [0:NW];
   logic [NW-1:0] c_quo [0:NW];
   logic [CW-1:0] c_pay [0:NW];

   assign c_ctl[0] = s1_ctl_ff;
   assign c_num[0] = num0;
   assign c_den[0] = s1_mb_ff;
   assign c_rem[0] = '0;
   assign c_quo[0] = '0;
   assign c_pay[0] = {prod, s1_simple_ff};

   genvar gi;
   generate
      for (gi = 0; gi < NW; gi++) begin : g_cell
         fqa_div_cell #(
            .NW(NW), .DW(W), .PW(CW), .BIT(NW - 1 - gi)
         ) u_cell (
            .clock   (clock),
            .reset   (reset),
            .en      (adv),
            .ctl_in  (c_ctl[gi]),
            .num_in  (c_num[gi]),
            .den_in  (c_den[gi]),
            .rem_in  (c_rem[gi]),
            .quo_in  (c_quo[gi]),
            .pay_in  (c_pay[gi]),
            .ctl_out (c_ctl[gi+1]),
            .num_out (c_num[gi+1]),
            .den_out (c_den[gi+1]),
            .rem_out (c_rem[gi+1]),
            .quo_out (c_quo[gi+1]),
            .pay_out (c_pay[gi+1])
         );
      end
   endgenerate

   // ---- final stage: rounding, saturation, result select
   ctl_type       fc;
   logic [PW-1:0] fprod;
   logic [W+3:0]  fsimple;
   assign fc      = c_ctl[NW];
   assign fprod   = c_pay[NW][CW-1:W+4];
   assign fsimple = c_pay[NW][W+3:0];

   logic [PW:0]   mrnd;
   logic [PW:0]   mmag;
   logic [NW:0]   dmag;
   logic [PWX-1:0] mag;
   logic [PWX-1:0] lim;
   logic [W-1:0]  fres;
   logic          fovf;
   rsp_type       rsp_in;

   always_comb begin
      mrnd = {1'b0, fprod} + (PW+1)'(1) * ((PW+1)'(1) << (FRAC_BITS - 1));
      mmag = mrnd >> FRAC_BITS;
      dmag = ({1'b0, c_quo[NW]} + (NW+1)'(1)) >> 1;
      mag  = (fc.op == OP_MUL) ? PWX'(mmag) : PWX'(dmag);
      lim  = fc.neg ? PWX'({1'b1, {(W-1){1'b0}}}) : PWX'({1'b0, {(W-1){1'b1}}});
      fres = fsimple[W+3:4];
      fovf = fsimple[0];
      if (fc.op == OP_MUL || fc.op == OP_DIV) begin
         if (fc.op == OP_DIV && fc.dz) begin
            fovf = 1'b1;
            fres = s_sign_sat(fc.neg, 1'b1);
         end else if (mag > lim) begin
            fovf = 1'b1;
            fres = fc.neg ? mn : mx;
         end else begin
            fovf = 1'b0;
            fres = fc.neg ? W'(-mag[W-1:0]) : mag[W-1:0];
         end
      end
      rsp_in.result_raw     = IO_WIDTH'(signed'(fres));
      rsp_in.a_greater      = fsimple[3];
      rsp_in.a_less         = fsimple[2];
      rsp_in.a_equal        = fsimple[1];
      rsp_in.overflow_flag  = fovf;
      rsp_in.divide_by_zero = (fc.op == OP_DIV) && fc.dz;
   end

   logic    out_valid_ff;
   rsp_type out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= fc.valid;
      end
      if (adv) begin
         out_data_ff <= rsp_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   `FQA_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `FQA_ASSERT_SAME(a_dz_ovf, clock, reset, rsp_valid && rsp_data.divide_by_zero,
      rsp_data.overflow_flag)
   `FQA_ASSERT_SAME(a_cmp_onehot, clock, reset, rsp_valid,
      $onehot0({rsp_data.a_greater, rsp_data.a_less, rsp_data.a_equal}))

endmodule

// File: dv/tb_fixed_point_q8_alu.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the Q24.8 fixed-point ALU
// Directed corner operands for every operation, then random traffic with
// random idling on both sides and one long result-side stall; results checked
// in order against a predictor.
module tb_fixed_point_q8_alu;
   import fqa_pkg::*;

   localparam int FRAC = 8;
   localparam int LATENCY = 44;
   localparam int HOLD_LEN = 200;
   localparam logic signed [31:0] MAX_RAW = 32'sh7fffffff;
   localparam logic signed [31:0] MIN_RAW = 32'sh80000000;

   logic           clock = 1'b0;
   logic           reset = 1'b1;
   logic           req_valid = 1'b0;
   logic           req_stall;
   req_type_t_type req_data = '0;
   logic           rsp_valid;
   logic           rsp_stall = 1'b0;
   rsp_type        rsp_data;

   req_type_t_type pending_reqs[$];
   rsp_type        expected_rsps[$];
   int             mismatches = 0;
   int             send_idle_pct = 0;
   int             recv_idle_pct = 0;
   int             hold_req = 0;
   int             hold_seen = 0;
   int             hold_cycles = 0;

   fixed_point_q8_alu dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always #10 clock = ~clock;

   function automatic rsp_type predict_alu(req_type_t_type rq);
      rsp_type r;
      logic signed [63:0] a, b, s;
      logic [127:0] mag, q;
      logic [63:0] ma, mb;
      logic neg;
      r = '0;
      a = rq.operand_a;
      b = rq.operand_b;
      ma = a[63] ? -a : a;
      mb = b[63] ? -b : b;
      neg = a[63] ^ b[63];
      mag = '0;
      case (rq.req_type)
         OP_ADD, OP_SUB: begin
            s = (rq.req_type == OP_ADD) ? a + b : a - b;
            if (s > MAX_RAW) begin r.result_raw = MAX_RAW; r.overflow_flag = 1; end
            else if (s < MIN_RAW) begin r.result_raw = MIN_RAW; r.overflow_flag = 1; end
            else r.result_raw = s[31:0];
         end
         OP_MUL, OP_DIV: begin
            if (rq.req_type == OP_MUL) begin
               mag = ((128'(ma) * 128'(mb)) + (128'(1) << (FRAC - 1))) >> FRAC;
            end else if (b == 0) begin
               r.divide_by_zero = 1;
               r.overflow_flag = 1;
               r.result_raw = a[63] ? MIN_RAW : MAX_RAW;
            end else begin
               q = (128'(ma) << (FRAC + 1)) / 128'(mb);
               mag = (q + 1) >> 1;
            end
            if (!r.divide_by_zero) begin
               if (mag > (neg ? 128'h80000000 : 128'h7fffffff)) begin
                  r.overflow_flag = 1;
                  r.result_raw = neg ? MIN_RAW : MAX_RAW;
               end else begin
                  r.result_raw = neg ? -mag[31:0] : mag[31:0];
               end
            end
         end
         OP_CMP, OP_MIN, OP_MAX: begin
            r.a_greater = a > b;
            r.a_less = a < b;
            r.a_equal = a == b;
            if (rq.req_type == OP_MIN) r.result_raw = (a < b) ? a[31:0] : b[31:0];
            if (rq.req_type == OP_MAX) r.result_raw = (a > b) ? a[31:0] : b[31:0];
         end
         OP_INC: begin
            if (a == MAX_RAW) begin r.overflow_flag = 1; r.result_raw = MAX_RAW; end
            else r.result_raw = a[31:0] + 1;
         end
         OP_DEC: begin
            if (a == MIN_RAW) begin r.overflow_flag = 1; r.result_raw = MIN_RAW; end
            else r.result_raw = a[31:0] - 1;
         end
         OP_I2F: begin
            if (a > (MAX_RAW >>> FRAC)) begin r.overflow_flag = 1; r.result_raw = MAX_RAW; end
            else if (a < (MIN_RAW >>> FRAC)) begin
               r.overflow_flag = 1;
               r.result_raw = MIN_RAW;
            end else r.result_raw = a[31:0] << FRAC;
         end
         OP_F2I: r.result_raw = rq.operand_a >>> FRAC;
         default: ;
      endcase
      return r;
   endfunction

   function automatic logic [31:0] rand_operand();
      case ($urandom_range(0, 7))
         0: return MAX_RAW - $urandom_range(0, 3);
         1: return MIN_RAW + $urandom_range(0, 3);
         2: return $urandom_range(0, 600) - 300;
         3: return ($urandom_range(0, 1) ? 32'(1) : -32'(1)) * $urandom_range(0, 32'h7fff) << 8;
         4: return 32'(signed'($urandom)) >>> $urandom_range(0, 30);
         default: return $urandom;
      endcase
   endfunction

   task automatic queue_req(logic [3:0] op, logic [31:0] a, logic [31:0] b);
      req_type_t_type rq;
      rq.req_type = op;
      rq.operand_a = a;
      rq.operand_b = b;
      pending_reqs.push_back(rq);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) expected_rsps.push_back(predict_alu(req_data));
         if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_data <= pending_reqs.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_cycles <= 0;
         hold_seen <= 0;
      end else begin
         if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_cycles <= HOLD_LEN;
            rsp_stall <= 1'b1;
         end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected transaction: %p", rsp_data);
         end else begin
            exp_rsp = expected_rsps.pop_front();
            if (rsp_data !== exp_rsp) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %p, actual %p", exp_rsp, rsp_data);
            end
         end
      end
   end

   task automatic drain();
      while (pending_reqs.size() > 0 || req_valid) @(posedge clock);
      while (expected_rsps.size() > 0) @(posedge clock);
   endtask

   task automatic add_random(int count);
      for (int i = 0; i < count; i++)
         queue_req(4'($urandom_range(0, 15)), rand_operand(), rand_operand());
   endtask

   initial begin
      logic [31:0] corners[6];
      corners = '{MAX_RAW, MIN_RAW, 32'd0, 32'd256, -32'sd256, 32'd1};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      foreach (corners[i]) queue_req(OP_ADD, corners[i], corners[(i + 1) % 6]);
      queue_req(OP_SUB, MIN_RAW, 32'd1);
      queue_req(OP_MUL, MIN_RAW, MIN_RAW);
      queue_req(OP_MUL, 32'd384, -32'sd128);
      queue_req(OP_DIV, -32'sd5, 32'd0);
      queue_req(OP_DIV, 32'd0, 32'd0);
      queue_req(OP_DIV, MIN_RAW, 32'hffffffff);
      queue_req(OP_DIV, 32'd256, 32'd768);
      queue_req(OP_CMP, 32'd7, 32'd7);
      queue_req(OP_MIN, MIN_RAW, MAX_RAW);
      queue_req(OP_MAX, MIN_RAW, MAX_RAW);
      queue_req(OP_INC, MAX_RAW, 32'd0);
      queue_req(OP_DEC, MIN_RAW, 32'd0);
      queue_req(OP_I2F, 32'h007fffff, 32'd0);
      queue_req(OP_I2F, 32'hff7fffff, 32'd0);
      queue_req(OP_F2I, -32'sd1, 32'd0);
      queue_req(4'd11, 32'd5, 32'd5);
      queue_req(4'd15, MAX_RAW, MIN_RAW);
      drain();
      send_idle_pct = 6;
      recv_idle_pct = 66;
      add_random(350);
      drain();
      hold_req++;
      add_random(120);
      drain();
      send_idle_pct = 66;
      recv_idle_pct = 6;
      add_random(300);
      drain();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      add_random(300);
      drain();
      repeat (LATENCY + 10) @(posedge clock);
      if (mismatches == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      #5ms;
      $display("CHECKS FAILED");
      $finish;
   end
endmodule
